// File: design/sdpd_pkg.sv
// Package: widths, reset values, payload types and speed shaping for the straight-drive PD block
`timescale 1ns / 1ps

package sdpd_pkg;

  // Base widths
  localparam int POSITION_WIDTH = 24;
  localparam int GAIN_FRAC_BITS = 16;
  localparam int GainW          = 16;
  localparam int HeadW          = 14;
  localparam int SpeedW         = 12;
  localparam int TolW           = 16;
  localparam int CntW           = 4;

  // Derived datapath widths
  localparam int ErrW   = POSITION_WIDTH + 1;
  localparam int DerW   = POSITION_WIDTH + 2;
  localparam int MagW   = (ErrW > TolW) ? ErrW : TolW;
  localparam int ProdPW = ErrW + GainW + 1;
  localparam int ProdDW = DerW + GainW + 1;
  localparam int ProdAW = HeadW + GainW + 1;
  localparam int SumW   = ProdDW + 2;
  localparam int CmdW   = SumW - GAIN_FRAC_BITS;

  // Configuration port
  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = (POSITION_WIDTH > GainW) ? POSITION_WIDTH : GainW;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_GOAL     = 3'd0,
    CFG_GAIN_P   = 3'd1,
    CFG_GAIN_D   = 3'd2,
    CFG_GAIN_A   = 3'd3,
    CFG_TOL      = 3'd4,
    CFG_SETTLE   = 3'd5
  } cfg_idx_e;

  // Reset values of the registers
  localparam logic [GainW-1:0] GainPRst  = GainW'(22938);
  localparam logic [GainW-1:0] GainDRst  = GainW'(6554);
  localparam logic [GainW-1:0] GainARst  = GainW'(3277);
  localparam logic [TolW-1:0]  TolRst    = TolW'(80);
  localparam logic [CntW-1:0]  SettleRst = CntW'(3);
  localparam logic [CntW-1:0]  CntMax    = '1;

  // Speed limits, 1/16 percent
  localparam logic signed [CmdW-1:0] CmdOnePct = CmdW'(16);
  localparam logic signed [CmdW-1:0] CmdMax    = CmdW'(1600);
  localparam logic signed [CmdW-1:0] CmdMin    = -CmdW'(1600);

  // Error stage payload
  typedef struct packed {
    logic signed [ErrW-1:0]  err;
    logic signed [DerW-1:0]  deriv;
    logic signed [HeadW-1:0] heading;
    logic                    done;
  } front_t;

  // Product stage payload
  typedef struct packed {
    logic signed [ProdPW-1:0] prod_p;
    logic signed [ProdDW-1:0] prod_d;
    logic signed [ProdAW-1:0] prod_a;
    logic                     done;
  } prod_t;

  // Floor to whole units, minimum push to one percent, saturate at 100 percent
  function automatic logic signed [SpeedW-1:0] shape_speed(input logic signed [SumW-1:0] s);
    logic signed [SumW-1:0] sh;
    logic signed [CmdW-1:0] v;
    logic                   s_neg;
    logic                   s_pos;
    sh    = s >>> GAIN_FRAC_BITS;
    v     = sh[CmdW-1:0];
    s_neg = s[SumW-1];
    s_pos = !s[SumW-1] && (s != '0);
    if (s_pos && (v < CmdOnePct)) v = CmdOnePct;
    if (s_neg && (v > -CmdOnePct)) v = -CmdOnePct;
    if (v > CmdMax) v = CmdMax;
    if (v < CmdMin) v = CmdMin;
    return v[SpeedW-1:0];
  endfunction

endpackage

// File: design/sdpd_if.sv
// Interfaces: sensor item channel and drive result channel
`timescale 1ns / 1ps

interface sdpd_in_if;
  logic                                    valid;
  logic                                    ready;
  logic                                    restart;
  logic signed [sdpd_pkg::POSITION_WIDTH-1:0] position;
  logic signed [sdpd_pkg::HeadW-1:0]       heading;

  modport source (output valid, restart, position, heading, input ready);
  modport sink   (input valid, restart, position, heading, output ready);
endinterface

interface sdpd_out_if;
  logic                              valid;
  logic                              ready;
  logic signed [sdpd_pkg::SpeedW-1:0] left_speed;
  logic signed [sdpd_pkg::SpeedW-1:0] right_speed;
  logic                              done_res;

  modport source (output valid, left_speed, right_speed, done_res, input ready);
  modport sink   (input valid, left_speed, right_speed, done_res, output ready);
endinterface

// File: design/sdpd_front.sv
// Error stage: error, derivative, settle counting and controller state
`timescale 1ns / 1ps

module sdpd_front (
  input  logic                                       clk_i,
  input  logic                                       rst_ni,
  input  logic                                       en_i,
  input  logic                                       take_i,
  input  logic                                       restart_i,
  input  logic signed [sdpd_pkg::POSITION_WIDTH-1:0] position_i,
  input  logic signed [sdpd_pkg::HeadW-1:0]          heading_i,
  input  logic signed [sdpd_pkg::POSITION_WIDTH-1:0] goal_i,
  input  logic [sdpd_pkg::TolW-1:0]                  tolerance_i,
  input  logic [sdpd_pkg::CntW-1:0]                  settle_i,
  output sdpd_pkg::front_t                           front_o
);

  logic signed [sdpd_pkg::ErrW-1:0] last_err_q;
  logic [sdpd_pkg::CntW-1:0]        hit_q, hit_base, hit_d;
  logic signed [sdpd_pkg::ErrW-1:0] err, last_eff;
  logic signed [sdpd_pkg::DerW-1:0] deriv;
  logic [sdpd_pkg::MagW-1:0]        mag;
  logic                             in_band;
  sdpd_pkg::front_t                 front_d, front_q;

  // Error and derivative; restart clears the previous error first
  always_comb begin
    last_eff = restart_i ? '0 : last_err_q;
    err      = sdpd_pkg::ErrW'(goal_i) - sdpd_pkg::ErrW'(position_i);
    deriv    = sdpd_pkg::DerW'(err) - sdpd_pkg::DerW'(last_eff);
  end

  // Settle counting: strict band, saturates at settle count
  always_comb begin
    mag      = err[sdpd_pkg::ErrW-1] ? sdpd_pkg::MagW'(unsigned'(-err))
                                     : sdpd_pkg::MagW'(unsigned'(err));
    in_band  = mag < sdpd_pkg::MagW'(tolerance_i);
    hit_base = restart_i ? '0 : hit_q;
    hit_d    = hit_base;
    if (in_band && (hit_base < settle_i) && (hit_base != sdpd_pkg::CntMax)) begin
      hit_d = hit_base + 1'b1;
    end
  end

  always_comb begin
    front_d.err     = err;
    front_d.deriv   = deriv;
    front_d.heading = heading_i;
    front_d.done    = hit_d >= settle_i;
  end

  // Controller state, updated once per accepted item
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_err_q <= '0;
      hit_q      <= '0;
    end else if (take_i) begin
      last_err_q <= err;
      hit_q      <= hit_d;
    end
  end

  // Stage register
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      front_q <= front_d;
    end
  end

  assign front_o = front_q;

endmodule

// File: design/sdpd_mult.sv
// Product stage: the three gain multiplications
`timescale 1ns / 1ps

module sdpd_mult (
  input  logic                        clk_i,
  input  logic                        en_i,
  input  sdpd_pkg::front_t            front_i,
  input  logic [sdpd_pkg::GainW-1:0]  gain_p_i,
  input  logic [sdpd_pkg::GainW-1:0]  gain_d_i,
  input  logic [sdpd_pkg::GainW-1:0]  gain_a_i,
  output sdpd_pkg::prod_t             prod_o
);

  logic signed [sdpd_pkg::GainW:0] gp_s, gd_s, ga_s;
  sdpd_pkg::prod_t                 prod_d, prod_q;

  // Gains are unsigned; a zero top bit keeps them positive in signed products
  always_comb begin
    gp_s          = {1'b0, gain_p_i};
    gd_s          = {1'b0, gain_d_i};
    ga_s          = {1'b0, gain_a_i};
    prod_d.prod_p = sdpd_pkg::ProdPW'(front_i.err) * sdpd_pkg::ProdPW'(gp_s);
    prod_d.prod_d = sdpd_pkg::ProdDW'(front_i.deriv) * sdpd_pkg::ProdDW'(gd_s);
    prod_d.prod_a = sdpd_pkg::ProdAW'(front_i.heading) * sdpd_pkg::ProdAW'(ga_s);
    prod_d.done   = front_i.done;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q <= prod_d;
    end
  end

  assign prod_o = prod_q;

endmodule

// File: design/sdpd_mix.sv
// Mix stage: side sums, speed shaping and the result register
`timescale 1ns / 1ps

module sdpd_mix (
  input  logic                               clk_i,
  input  logic                               en_i,
  input  sdpd_pkg::prod_t                    prod_i,
  output logic signed [sdpd_pkg::SpeedW-1:0] left_o,
  output logic signed [sdpd_pkg::SpeedW-1:0] right_o,
  output logic                               done_o
);

  logic signed [sdpd_pkg::SumW-1:0]   common, trim, sum_l, sum_r;
  logic signed [sdpd_pkg::SpeedW-1:0] left_d, right_d, left_q, right_q;
  logic                               done_q;

  // Heading trim: minus on the left, plus on the right
  always_comb begin
    common  = sdpd_pkg::SumW'(prod_i.prod_p) + sdpd_pkg::SumW'(prod_i.prod_d);
    trim    = sdpd_pkg::SumW'(prod_i.prod_a);
    sum_l   = common - trim;
    sum_r   = common + trim;
    left_d  = sdpd_pkg::shape_speed(sum_l);
    right_d = sdpd_pkg::shape_speed(sum_r);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      left_q  <= left_d;
      right_q <= right_d;
      done_q  <= prod_i.done;
    end
  end

  assign left_o  = left_q;
  assign right_o = right_q;
  assign done_o  = done_q;

endmodule

// File: design/straight_drive_pd_with_heading_trim.sv
// Top level: straight-drive PD controller with heading trim
//
//   channel   dir  handshake     payload
//   in_chan   in   valid/ready   restart, position, heading
//   res_chan  out  valid/ready   left_speed, right_speed, done_res
//   cfg       in   cfg_we_i      cfg_idx_i, cfg_wdata_i (write only)
//
// One item per cycle while the pipeline advances; each taken item passes through the error stage,
// the product stage and the mix stage, whose result register then holds its result.
// The whole pipeline advances whenever the result register is empty or being taken,
// so a held result stalls every stage and in_chan.ready falls with it.
// Reset clears the configuration to its defaults, the previous error, the hit count
// and the stage valid flags.
`timescale 1ns / 1ps

module straight_drive_pd_with_heading_trim (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  sdpd_in_if.sink                             in_chan,
  sdpd_out_if.source                          res_chan,
  input  logic                                cfg_we_i,
  input  logic [sdpd_pkg::CfgIdxW-1:0]        cfg_idx_i,
  input  logic [sdpd_pkg::CfgDataW-1:0]       cfg_wdata_i
);

  logic signed [sdpd_pkg::POSITION_WIDTH-1:0] goal_q;
  logic [sdpd_pkg::GainW-1:0]                 gain_p_q, gain_d_q, gain_a_q;
  logic [sdpd_pkg::TolW-1:0]                  tol_q;
  logic [sdpd_pkg::CntW-1:0]                  settle_q;

  logic              en, take;
  logic              v1_q, v2_q, v3_q;
  sdpd_pkg::front_t  front;
  sdpd_pkg::prod_t   prod;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      goal_q   <= '0;
      gain_p_q <= sdpd_pkg::GainPRst;
      gain_d_q <= sdpd_pkg::GainDRst;
      gain_a_q <= sdpd_pkg::GainARst;
      tol_q    <= sdpd_pkg::TolRst;
      settle_q <= sdpd_pkg::SettleRst;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        sdpd_pkg::CFG_GOAL:   goal_q   <= cfg_wdata_i[sdpd_pkg::POSITION_WIDTH-1:0];
        sdpd_pkg::CFG_GAIN_P: gain_p_q <= cfg_wdata_i[sdpd_pkg::GainW-1:0];
        sdpd_pkg::CFG_GAIN_D: gain_d_q <= cfg_wdata_i[sdpd_pkg::GainW-1:0];
        sdpd_pkg::CFG_GAIN_A: gain_a_q <= cfg_wdata_i[sdpd_pkg::GainW-1:0];
        sdpd_pkg::CFG_TOL:    tol_q    <= cfg_wdata_i[sdpd_pkg::TolW-1:0];
        sdpd_pkg::CFG_SETTLE: settle_q <= cfg_wdata_i[sdpd_pkg::CntW-1:0];
        default: ;
      endcase
    end
  end

  // Pipeline advance and item acceptance
  assign en            = !v3_q || res_chan.ready;
  assign take          = in_chan.valid && en;
  assign in_chan.ready = en;

  // Stage valid flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else if (en) begin
      v1_q <= in_chan.valid;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  sdpd_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .en_i        (en),
    .take_i      (take),
    .restart_i   (in_chan.restart),
    .position_i  (in_chan.position),
    .heading_i   (in_chan.heading),
    .goal_i      (goal_q),
    .tolerance_i (tol_q),
    .settle_i    (settle_q),
    .front_o     (front)
  );

  sdpd_mult u_mult (
    .clk_i    (clk_i),
    .en_i     (en),
    .front_i  (front),
    .gain_p_i (gain_p_q),
    .gain_d_i (gain_d_q),
    .gain_a_i (gain_a_q),
    .prod_o   (prod)
  );

  sdpd_mix u_mix (
    .clk_i   (clk_i),
    .en_i    (en),
    .prod_i  (prod),
    .left_o  (res_chan.left_speed),
    .right_o (res_chan.right_speed),
    .done_o  (res_chan.done_res)
  );

  assign res_chan.valid = v3_q;

endmodule
